// ===== rtl/core/dns_query_to_fixed_answer_macros.svh =====
// Assertion macros shared by the DNS responder RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef DNS_QUERY_TO_FIXED_ANSWER_MACROS_SVH
`define DNS_QUERY_TO_FIXED_ANSWER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DQFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DQFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dqfa_pkg.sv =====
// Shared types, constants and byte tables for the DNS fixed-answer responder.
// No dependencies.
package dqfa_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int ANSWER_BYTES = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] FLAGS_RESPONSE = 8'h80;
    localparam logic [7:0] NAME_POINTER   = 8'hC0;
    localparam logic [7:0] NAME_OFFSET    = 8'h0C;
    localparam logic [7:0] ANSWER_TTL     = 8'h78;
    localparam logic [7:0] ADDR_LENGTH    = 8'h04;

    // One classified query byte handed from the parser to the reply sequencer.
    typedef struct packed {
        logic       emit;  // a reply byte comes from this query byte
        logic [7:0] data;  // that reply byte
        logic       last;  // final query byte: append the answer record
        logic       drop;  // discard flag for the final reply byte
    } dqfa_entry_t;

    // Queue status seen by the sequencer.
    typedef struct packed {
        logic        not_empty;
        dqfa_entry_t head;
    } dqfa_queue_stat_t;

    // Header bytes 2..11 of the reply; ID bytes are passed through elsewhere.
    function automatic logic [7:0] header_fill(input logic [3:0] pos);
        logic [7:0] val;
        val = 8'h00;
        unique case (pos)
            4'd2:    val = FLAGS_RESPONSE;
            4'd5:    val = 8'h01;
            4'd7:    val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // Answer record byte: name pointer, type A, class IN, TTL, length, address.
    function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                               input logic [31:0] ip);
        logic [7:0] val;
        val = 8'h00;
        unique case (idx)
            4'd0:    val = NAME_POINTER;
            4'd1:    val = NAME_OFFSET;
            4'd3:    val = 8'h01;
            4'd5:    val = 8'h01;
            4'd9:    val = ANSWER_TTL;
            4'd11:   val = ADDR_LENGTH;
            4'd12:   val = ip[31:24];
            4'd13:   val = ip[23:16];
            4'd14:   val = ip[15:8];
            4'd15:   val = ip[7:0];
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/dqfa_front.sv =====
// Query parser: accepts and classifies a byte per cycle unless queue_full.
// Depends on dqfa_pkg; feeds dqfa_queue.
module dqfa_front #(
    parameter int MAX_QUERY_BYTES = 80
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 queue_full,
    output logic                 push,
    output dqfa_pkg::dqfa_entry_t push_entry
);
    import dqfa_pkg::*;

    localparam int IDX_W = $clog2(MAX_QUERY_BYTES + 2);
    localparam logic [IDX_W-1:0] IDX_SAT = IDX_W'(MAX_QUERY_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_QUERY_BYTES);
    localparam logic [IDX_W-1:0] IDX_HDR_END = IDX_W'(HEADER_BYTES - 1);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_NAME,
        PH_TYPECLASS,
        PH_DISCARD
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       tail_reg, tail_next;
    logic             accept;
    dqfa_entry_t      entry;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    // Classify the current byte and work out the next parser state.
    always_comb begin
        phase_next = phase_reg;
        tail_next  = tail_reg;
        idx_next   = (idx_reg < IDX_SAT) ? idx_reg + 1'b1 : idx_reg;
        entry      = '0;
        unique case (phase_reg)
            PH_HEADER: begin
                entry.emit = 1'b1;
                entry.data = (idx_reg < IDX_W'(2)) ? s_tdata : header_fill(idx_reg[3:0]);
                if (idx_reg >= IDX_HDR_END) begin
                    phase_next = PH_NAME;
                end
            end
            PH_NAME: begin
                entry.emit = 1'b1;
                entry.data = s_tdata;
                if (s_tdata == 8'h00) begin
                    phase_next = PH_TYPECLASS;
                    tail_next  = 2'd0;
                end
            end
            PH_TYPECLASS: begin
                entry.emit = 1'b1;
                entry.data = {7'd0, tail_reg[0]};
                tail_next  = tail_reg + 2'd1;
                if (tail_reg == 2'd3) begin
                    phase_next = PH_DISCARD;
                end
            end
            PH_DISCARD: begin
                entry.emit = 1'b0;
            end
            default: begin
                entry.emit = 1'b0;
            end
        endcase
        entry.last = s_tlast;
        entry.drop = (idx_next > IDX_MAX) || (phase_next != PH_DISCARD);
    end

    assign push       = accept && (entry.emit || entry.last);
    assign push_entry = entry;

    // Parser state; a final byte returns it to the start of a datagram.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            idx_reg   <= '0;
            tail_reg  <= 2'd0;
        end else if (accept) begin
            if (s_tlast) begin
                phase_reg <= PH_HEADER;
                idx_reg   <= '0;
                tail_reg  <= 2'd0;
            end else begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                tail_reg  <= tail_next;
            end
        end
    end

endmodule

// ===== rtl/core/dqfa_queue.sv =====
// Short FIFO of classified bytes between the parser and the reply sequencer.
// Depends on dqfa_pkg and the assertion macro header.
`include "dns_query_to_fixed_answer_macros.svh"
module dqfa_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  dqfa_pkg::dqfa_entry_t      push_entry,
    output logic                       full,
    input  logic                       pop,
    output dqfa_pkg::dqfa_queue_stat_t stat
);
    import dqfa_pkg::*;

    dqfa_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full           = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign stat.not_empty = (count_reg != '0);
    assign stat.head      = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `DQFA_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into a full queue")
    `DQFA_ASSERT_NOW(a_no_underflow, pop, stat.not_empty, "pop from an empty queue")

endmodule

// ===== rtl/core/dqfa_back.sv =====
// Reply sequencer: turns queued entries into reply bytes and answer records.
// Depends on dqfa_pkg and the assertion macro header.
`include "dns_query_to_fixed_answer_macros.svh"
module dqfa_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dqfa_pkg::dqfa_queue_stat_t stat,
    output logic                       pop,
    input  logic [31:0]                answer_ip,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,
    output logic                       m_tlast,
    output logic [0:0]                 m_tuser
);
    import dqfa_pkg::*;

    localparam logic [3:0] ANS_LAST = 4'(ANSWER_BYTES - 1);

    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_drop_reg;
    logic       ans_active_reg;
    logic [3:0] ans_idx_reg;
    logic       drop_reg;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = out_free && !ans_active_reg && stat.not_empty;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_drop_reg;

    // Output register and answer-record counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            ans_active_reg <= 1'b0;
            ans_idx_reg    <= 4'd0;
            drop_reg       <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_drop_reg  <= 1'b0;
            if (ans_active_reg) begin
                // Continue the answer record.
                out_valid_reg <= 1'b1;
                out_data_reg  <= answer_byte(ans_idx_reg, answer_ip);
                out_last_reg  <= (ans_idx_reg == ANS_LAST);
                out_drop_reg  <= (ans_idx_reg == ANS_LAST) && drop_reg;
                ans_idx_reg   <= ans_idx_reg + 4'd1;
                if (ans_idx_reg == ANS_LAST) begin
                    ans_active_reg <= 1'b0;
                end
            end else if (stat.not_empty) begin
                out_valid_reg <= 1'b1;
                if (stat.head.emit) begin
                    // Reply byte of the query itself; the answer follows if last.
                    out_data_reg   <= stat.head.data;
                    ans_active_reg <= stat.head.last;
                    ans_idx_reg    <= 4'd0;
                end else begin
                    // Final byte without its own reply byte: start the answer now.
                    out_data_reg   <= answer_byte(4'd0, answer_ip);
                    ans_active_reg <= 1'b1;
                    ans_idx_reg    <= 4'd1;
                end
                drop_reg <= stat.head.drop;
            end
        end
    end

    `DQFA_ASSERT_NOW(a_no_pop_in_answer, ans_active_reg, !pop, "queue popped during answer")
    `DQFA_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(ans_idx_reg), "output or counter moved during stall")

endmodule

// ===== rtl/core/dns_query_to_fixed_answer.sv =====
// Captive-portal DNS responder: replies to every query with one IPv4 address.
// Depends on dqfa_pkg, dqfa_front, dqfa_queue and dqfa_back.
//
// Usage:
//   The query datagram enters on the s_ channel one byte per transaction,
//   s_tlast on its final byte. The reply leaves on the m_ channel one byte
//   per transaction: rewritten header, the query name, type A / class IN,
//   then a 16-byte answer record. m_tlast marks the final reply byte and
//   m_tuser flags on that byte that the whole reply is to be discarded
//   (query longer than MAX_QUERY_BYTES or question cut short).
//   The user writes the cfg_ answer address only while idle (not enforced).
// Timing:
//   One query byte is taken per cycle while s_tready is high; its reply byte
//   passes through the queue and the output register. A final byte makes 17
//   output transactions (16 if it was a trailing byte), one per cycle while
//   m_tready is high; at full rate the four-entry queue then fills up.
// Reset and stall:
//   aresetn (synchronous, active low) empties the queue, returns the parser
//   to the header and sets the address to 0.0.0.0. When m_tready is low the
//   output byte holds; s_tready drops only once the queue fills.
module dns_query_to_fixed_answer #(
    parameter int MAX_QUERY_BYTES = 80
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] query_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] reply_byte
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // [0] reply_drop
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import dqfa_pkg::*;

    logic             queue_full;
    logic             push;
    logic             pop;
    dqfa_entry_t      push_entry;
    dqfa_queue_stat_t stat;
    logic [31:0]      answer_ip_reg;

    // Answer address register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            answer_ip_reg <= 32'd0;
        end else if (cfg_valid && cfg_ready) begin
            answer_ip_reg <= cfg_data;
        end
    end

    dqfa_front #(
        .MAX_QUERY_BYTES(MAX_QUERY_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    dqfa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .stat       (stat)
    );

    dqfa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stat      (stat),
        .pop       (pop),
        .answer_ip (answer_ip_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
